// ----- design/quaternion_to_yaw_pitch_roll_core_defines.svh -----
// Assertion macros for the quaternion to yaw/pitch/roll core.
// Depends on clk_i and rst_ni being in scope where used.
`ifndef QUATERNION_TO_YAW_PITCH_ROLL_CORE_DEFINES_SVH
`define QUATERNION_TO_YAW_PITCH_ROLL_CORE_DEFINES_SVH
`ifndef SYNTH
`define QTYPR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("qtypr assertion failed");
`define QTYPR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("qtypr assertion failed");
`else
`define QTYPR_ASSERT_IMP(lbl, ante, cons)
`define QTYPR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ----- design/qtypr_pkg.sv -----
// Package for the quaternion to yaw/pitch/roll core: item types, widths, CORDIC table.
// No dependencies.
package qtypr_pkg;

  localparam int unsigned COMP_W      = 16;
  localparam int unsigned ANGLE_W     = 16;
  localparam int unsigned CORDIC_N    = 16;
  localparam int unsigned ACC_W       = 32;
  localparam int unsigned ATAN_IN_W   = 36;
  localparam int unsigned WORK_W      = 64;
  localparam int unsigned NORM_N      = 6;
  localparam int unsigned ISQRT_N     = 31;
  localparam int unsigned ATAN_LAT    = NORM_N + CORDIC_N + 2;
  localparam int unsigned CORE_LAT    = 4 + ISQRT_N + ATAN_LAT + 1;

  localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
    32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
  };

  typedef struct packed {
    logic signed [COMP_W-1:0] quat_x;
    logic signed [COMP_W-1:0] quat_y;
    logic signed [COMP_W-1:0] quat_z;
    logic signed [COMP_W-1:0] quat_w;
  } quat_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] yaw_angle;
    logic signed [ANGLE_W-1:0] pitch_angle;
    logic signed [ANGLE_W-1:0] roll_angle;
  } euler_t;

endpackage

// ----- design/qtypr_atan2.sv -----
// Pipelined atan2: normalize, quadrant fold, vectoring CORDIC, round.
// Depends on qtypr_pkg.
module qtypr_atan2 (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  input  logic signed [qtypr_pkg::ATAN_IN_W-1:0] y_i,
  input  logic signed [qtypr_pkg::ATAN_IN_W-1:0] x_i,
  output logic                                   valid_o,
  output logic signed [qtypr_pkg::ANGLE_W-1:0]   angle_o
);
  import qtypr_pkg::*;

  logic signed [WORK_W-1:0] nx [NORM_N+1];
  logic signed [WORK_W-1:0] ny [NORM_N+1];
  logic        [WORK_W-1:0] nm [NORM_N+1];
  logic                     nz [NORM_N+1];
  logic                     nv [NORM_N+1];
  logic [ATAN_IN_W-1:0]     mag_x, mag_y;

  always_comb begin
    mag_x = x_i[ATAN_IN_W-1] ? ATAN_IN_W'(-x_i) : ATAN_IN_W'(x_i);
    mag_y = y_i[ATAN_IN_W-1] ? ATAN_IN_W'(-y_i) : ATAN_IN_W'(y_i);
    nx[0] = WORK_W'(x_i);
    ny[0] = WORK_W'(y_i);
    nm[0] = WORK_W'(mag_x | mag_y);
    nz[0] = (x_i == '0) && (y_i == '0);
    nv[0] = valid_i;
  end

  for (genvar j = 0; j < NORM_N; j++) begin : g_norm
    localparam int unsigned K = 32 >> j;
    localparam logic [WORK_W-1:0] LIMIT = WORK_W'(1) << (60 - K);
    logic signed [WORK_W-1:0] x_q, y_q;
    logic        [WORK_W-1:0] m_q;
    logic                     z_q, v_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= nv[j];
      end
    end
    always_ff @(posedge clk_i) begin
      z_q <= nz[j];
      if (nm[j] < LIMIT) begin
        x_q <= nx[j] <<< K;
        y_q <= ny[j] <<< K;
        m_q <= nm[j] << K;
      end else begin
        x_q <= nx[j];
        y_q <= ny[j];
        m_q <= nm[j];
      end
    end
    assign nx[j+1] = x_q;
    assign ny[j+1] = y_q;
    assign nm[j+1] = m_q;
    assign nz[j+1] = z_q;
    assign nv[j+1] = v_q;
  end

  logic signed [WORK_W-1:0] cx [CORDIC_N+1];
  logic signed [WORK_W-1:0] cy [CORDIC_N+1];
  logic        [ACC_W-1:0]  ca [CORDIC_N+1];
  logic                     cz [CORDIC_N+1];
  logic                     cv [CORDIC_N+1];

  logic signed [WORK_W-1:0] rx_q, ry_q;
  logic        [ACC_W-1:0]  ra_q;
  logic                     rz_q, rv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rv_q <= 1'b0;
    end else begin
      rv_q <= nv[NORM_N];
    end
  end

  always_ff @(posedge clk_i) begin
    rz_q <= nz[NORM_N];
    if (nx[NORM_N] < 0) begin
      if (ny[NORM_N] >= 0) begin
        rx_q <= ny[NORM_N];
        ry_q <= -nx[NORM_N];
        ra_q <= QUARTER_TURN;
      end else begin
        rx_q <= -ny[NORM_N];
        ry_q <= nx[NORM_N];
        ra_q <= -QUARTER_TURN;
      end
    end else begin
      rx_q <= nx[NORM_N];
      ry_q <= ny[NORM_N];
      ra_q <= '0;
    end
  end

  assign cx[0] = rx_q;
  assign cy[0] = ry_q;
  assign ca[0] = ra_q;
  assign cz[0] = rz_q;
  assign cv[0] = rv_q;

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_cordic
    logic signed [WORK_W-1:0] x_q, y_q;
    logic        [ACC_W-1:0]  a_q;
    logic                     z_q, v_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= cv[i];
      end
    end
    always_ff @(posedge clk_i) begin
      z_q <= cz[i];
      if (cy[i] >= 0) begin
        x_q <= cx[i] + (cy[i] >>> i);
        y_q <= cy[i] - (cx[i] >>> i);
        a_q <= ca[i] + ATAN_TURNS[i];
      end else begin
        x_q <= cx[i] - (cy[i] >>> i);
        y_q <= cy[i] + (cx[i] >>> i);
        a_q <= ca[i] - ATAN_TURNS[i];
      end
    end
    assign cx[i+1] = x_q;
    assign cy[i+1] = y_q;
    assign ca[i+1] = a_q;
    assign cz[i+1] = z_q;
    assign cv[i+1] = v_q;
  end

  logic [ACC_W-1:0] rounded;
  assign rounded = ca[CORDIC_N] + (ACC_W'(1) << (ACC_W - ANGLE_W - 1));

  logic                      out_v_q;
  logic signed [ANGLE_W-1:0] angle_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= cv[CORDIC_N];
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q <= cz[CORDIC_N] ? '0 : rounded[ACC_W-1 -: ANGLE_W];
  end

  assign valid_o = out_v_q;
  assign angle_o = angle_q;

endmodule

// ----- design/quaternion_to_yaw_pitch_roll_core.sv -----
// Throughput: one item per cycle; busy stays low, the 31-step square root
// and 16-stage CORDIC pipelines take a new item every cycle.
// Reset (rst_ni low, asynchronous) clears all valid bits; no result is lost
// to the receiver, which cannot stall.
`include "quaternion_to_yaw_pitch_roll_core_defines.svh"
module quaternion_to_yaw_pitch_roll_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  qtypr_pkg::quat_t  quat_i,
  output logic              busy,
  output logic              done_o,
  output qtypr_pkg::euler_t result_o
);
  import qtypr_pkg::*;

  localparam int unsigned SUM_W = 35;
  localparam int unsigned SQ_W  = 62;

  typedef struct packed {
    logic signed [SUM_W-1:0] yaw_y;
    logic signed [SUM_W-1:0] yaw_x;
    logic signed [SUM_W-1:0] roll_y;
    logic signed [SUM_W-1:0] roll_x;
    logic signed [31:0]      s;
  } side_t;

  assign busy = 1'b0;

  // products
  logic                v1_q;
  logic signed [31:0]  xx_q, yy_q, zz_q, ww_q, xy_q, wz_q, wy_q, xz_q, yz_q, wx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    xx_q <= quat_i.quat_x * quat_i.quat_x;
    yy_q <= quat_i.quat_y * quat_i.quat_y;
    zz_q <= quat_i.quat_z * quat_i.quat_z;
    ww_q <= quat_i.quat_w * quat_i.quat_w;
    xy_q <= quat_i.quat_x * quat_i.quat_y;
    wz_q <= quat_i.quat_w * quat_i.quat_z;
    wy_q <= quat_i.quat_w * quat_i.quat_y;
    xz_q <= quat_i.quat_x * quat_i.quat_z;
    yz_q <= quat_i.quat_y * quat_i.quat_z;
    wx_q <= quat_i.quat_w * quat_i.quat_x;
  end

  // sums and asin argument clamp
  logic signed [SUM_W-1:0] s_raw;
  logic signed [31:0]      s_clamp;
  side_t                   side2_d, side2_q;
  logic                    v2_q;

  always_comb begin
    s_raw = (SUM_W'(wy_q) - SUM_W'(xz_q)) <<< 1;
    if (s_raw > SUM_W'(1 << 30)) begin
      s_clamp = 32'sd1 <<< 30;
    end else if (s_raw < -SUM_W'(1 << 30)) begin
      s_clamp = -(32'sd1 <<< 30);
    end else begin
      s_clamp = 32'(s_raw);
    end
    side2_d.yaw_y  = (SUM_W'(xy_q) + SUM_W'(wz_q)) <<< 1;
    side2_d.yaw_x  = SUM_W'(ww_q) + SUM_W'(xx_q) - SUM_W'(yy_q) - SUM_W'(zz_q);
    side2_d.roll_y = (SUM_W'(yz_q) + SUM_W'(wx_q)) <<< 1;
    side2_d.roll_x = SUM_W'(xx_q) + SUM_W'(yy_q) - SUM_W'(ww_q) - SUM_W'(zz_q);
    side2_d.s      = s_clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side2_q <= side2_d;
  end

  // square of the sine
  logic [30:0]     s_abs;
  logic [SQ_W-1:0] sq_q;
  side_t           side3_q;
  logic            v3_q;

  assign s_abs = side2_q.s[31] ? 31'(-side2_q.s) : 31'(side2_q.s);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q    <= SQ_W'(s_abs) * SQ_W'(s_abs);
    side3_q <= side2_q;
  end

  // integer square root of one^2 - s^2, one result bit per stage
  logic [SQ_W-1:0] rem  [ISQRT_N+1];
  logic [SQ_W-1:0] root [ISQRT_N+1];
  side_t           side [ISQRT_N+1];
  logic            sv   [ISQRT_N+1];
  logic [SQ_W-1:0] rad_q;
  side_t           side4_q;
  logic            v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rad_q   <= (SQ_W'(1) << 60) - sq_q;
    side4_q <= side3_q;
  end

  assign rem[0]  = rad_q;
  assign root[0] = '0;
  assign side[0] = side4_q;
  assign sv[0]   = v4_q;

  for (genvar k = 0; k < ISQRT_N; k++) begin : g_isqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (60 - 2 * k);
    logic [SQ_W-1:0] trial;
    logic [SQ_W-1:0] rem_q, root_q;
    side_t           side_q;
    logic            v_q;
    assign trial = root[k] + BIT;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= sv[k];
      end
    end
    always_ff @(posedge clk_i) begin
      side_q <= side[k];
      if (rem[k] >= trial) begin
        rem_q  <= rem[k] - trial;
        root_q <= (root[k] >> 1) + BIT;
      end else begin
        rem_q  <= rem[k];
        root_q <= root[k] >> 1;
      end
    end
    assign rem[k+1]  = rem_q;
    assign root[k+1] = root_q;
    assign side[k+1] = side_q;
    assign sv[k+1]   = v_q;
  end

  // three atan2 pipelines
  logic signed [ATAN_IN_W-1:0] pitch_x;
  logic                        yaw_v, pitch_v, roll_v;
  logic signed [ANGLE_W-1:0]   yaw_a, pitch_a, roll_a;

  assign pitch_x = ATAN_IN_W'(root[ISQRT_N][30:0]);

  qtypr_atan2 u_yaw (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sv[ISQRT_N]),
    .y_i     (ATAN_IN_W'(side[ISQRT_N].yaw_y)),
    .x_i     (ATAN_IN_W'(side[ISQRT_N].yaw_x)),
    .valid_o (yaw_v),
    .angle_o (yaw_a)
  );

  qtypr_atan2 u_pitch (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sv[ISQRT_N]),
    .y_i     (ATAN_IN_W'(side[ISQRT_N].s)),
    .x_i     (pitch_x),
    .valid_o (pitch_v),
    .angle_o (pitch_a)
  );

  qtypr_atan2 u_roll (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sv[ISQRT_N]),
    .y_i     (ATAN_IN_W'(side[ISQRT_N].roll_y)),
    .x_i     (ATAN_IN_W'(side[ISQRT_N].roll_x)),
    .valid_o (roll_v),
    .angle_o (roll_a)
  );

  // output register
  localparam logic signed [ANGLE_W-1:0] NEG_PI = {1'b1, {(ANGLE_W-1){1'b0}}};
  localparam logic signed [ANGLE_W-1:0] POS_MAX = {1'b0, {(ANGLE_W-1){1'b1}}};

  logic   done_q;
  euler_t result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= yaw_v & pitch_v & roll_v;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.yaw_angle   <= yaw_a;
    result_q.pitch_angle <= -pitch_a;
    result_q.roll_angle  <= (roll_a == NEG_PI) ? POS_MAX : -roll_a;
  end

  assign done_o   = done_q;
  assign result_o = result_q;

  `QTYPR_ASSERT_IMP(a_lat, start, ##CORE_LAT done_o)
  `QTYPR_ASSERT_IMP(a_pitch_rng, done_o, result_o.pitch_angle <= 16384 && result_o.pitch_angle >= -16384)
  `QTYPR_ASSERT_IMP(a_roll_sat, done_o, result_o.roll_angle != NEG_PI)
  `QTYPR_ASSERT_IMP(a_zero, start && quat_i == '0, ##CORE_LAT result_o == '0)
  `QTYPR_ASSERT_NXT(a_lanes, sv[ISQRT_N], ##(ATAN_LAT - 1) (yaw_v && pitch_v && roll_v))

endmodule

// ----- sim/tb_quaternion_to_yaw_pitch_roll_core.sv -----
// Testbench for quaternion_to_yaw_pitch_roll_core: directed and random quaternions,
// predicted Euler angles compared field by field. Depends on qtypr_pkg and the core RTL.
`timescale 1ns / 100ps
module tb_quaternion_to_yaw_pitch_roll_core;
  import qtypr_pkg::*;

  localparam int unsigned LAT_CYC = 60;
  localparam int unsigned LIMIT_CYC = 200000;
  localparam longint NORM_LO = 64'sd1 <<< 59;
  localparam longint NORM_HI = 64'sd1 <<< 60;

  typedef struct {
    quat_t q;
    int    gap;
    bit    drain;
  } quat_job_t;

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   start = 1'b0;
  quat_t  quat_i = '0;
  logic   busy;
  logic   done_o;
  euler_t result_o;

  quat_job_t quat_jobs[$];
  euler_t    euler_expected[$];
  int        n_accepted = 0;
  int        n_returned = 0;
  int        n_errors = 0;
  int        cycles = 0;
  int        gap_left = 0;
  bit        armed = 1'b0;

  quaternion_to_yaw_pitch_roll_core u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .quat_i  (quat_i),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint mag64(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [ANGLE_W-1:0] cordic_angle(longint y, longint x);
    logic [31:0] acc;
    longint      t;
    longint      dx;
    longint      dy;
    logic [31:0] rnd;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    while ((mag64(x) > mag64(y) ? mag64(x) : mag64(y)) >= NORM_HI) begin
      x = x >>> 1;
      y = y >>> 1;
    end
    while ((mag64(x) > mag64(y) ? mag64(x) : mag64(y)) < NORM_LO) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t;
        acc = QUARTER_TURN;
      end else begin
        t = x; x = -y; y = t;
        acc = 32'd0 - QUARTER_TURN;
      end
    end
    for (int i = 0; i < CORDIC_N; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx; y = y - dy; acc = acc + ATAN_TURNS[i];
      end else begin
        x = x - dx; y = y + dy; acc = acc - ATAN_TURNS[i];
      end
    end
    rnd = (acc + (32'd1 << (31 - ANGLE_W))) >> (32 - ANGLE_W);
    return rnd[ANGLE_W-1:0];
  endfunction

  function automatic euler_t euler_of(quat_t q);
    longint qx, qy, qz, qw;
    longint s, one;
    longint unsigned c;
    logic signed [ANGLE_W-1:0] a;
    euler_t e;
    qx = q.quat_x; qy = q.quat_y; qz = q.quat_z; qw = q.quat_w;
    one = 64'sd1 <<< 30;
    e.yaw_angle = cordic_angle(2 * (qx * qy + qw * qz), qw * qw + qx * qx - qy * qy - qz * qz);
    s = 2 * (qw * qy - qx * qz);
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = int_sqrt(longint'(one * one) - longint'(s * s));
    a = cordic_angle(s, longint'(c));
    e.pitch_angle = -a;
    a = cordic_angle(2 * (qy * qz + qw * qx), -qw * qw + qx * qx + qy * qy - qz * qz);
    e.roll_angle = (a == {1'b1, {(ANGLE_W-1){1'b0}}}) ? {1'b0, {(ANGLE_W-1){1'b1}}} : -a;
    return e;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
  endtask

  task automatic add_quat(int x, int y, int z, int w, bit drain = 1'b0);
    quat_job_t j;
    j.q.quat_x = x[15:0]; j.q.quat_y = y[15:0];
    j.q.quat_z = z[15:0]; j.q.quat_w = w[15:0];
    j.gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 9) < 4) j.gap = 0;
    j.drain = drain;
    quat_jobs = {quat_jobs, j};
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    bit go;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      go = 1'b0;
      if (start && !busy) begin
        euler_expected = {euler_expected, euler_of(quat_i)};
        n_accepted++;
      end
      if (start && busy) begin
        go = 1'b1;
      end else if (quat_jobs.size() > 0) begin
        if (!armed) begin
          gap_left = quat_jobs[0].gap;
          armed = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
        end else if (!quat_jobs[0].drain || (n_accepted == n_returned && !start)) begin
          quat_i <= quat_jobs[0].q;
          void'(quat_jobs.pop_front());
          armed = 1'b0;
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    euler_t e;
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYC) begin
      $display("TB_ERROR");
      $finish;
    end else if (rst_ni && done_o) begin
      n_returned <= n_returned + 1;
      if (euler_expected.size() == 0) begin
        report_mismatch("unexpected item", 0, 0);
      end else begin
        e = euler_expected.pop_front();
        if (result_o.yaw_angle !== e.yaw_angle)
          report_mismatch("yaw", result_o.yaw_angle, e.yaw_angle);
        if (result_o.pitch_angle !== e.pitch_angle)
          report_mismatch("pitch", result_o.pitch_angle, e.pitch_angle);
        if (result_o.roll_angle !== e.roll_angle)
          report_mismatch("roll", result_o.roll_angle, e.roll_angle);
      end
    end
  end

  initial begin
    real a, b, c, d, n;
    add_quat(0, 0, 0, 0);
    add_quat(0, 0, 0, 32767);
    add_quat(0, 0, 0, -32768);
    add_quat(32767, 0, 0, 0);
    add_quat(0, 32767, 0, 0);
    add_quat(0, 0, 32767, 0);
    add_quat(-32768, -32768, -32768, -32768);
    add_quat(32767, 32767, 32767, 32767);
    add_quat(-32768, 32767, -32768, 32767);
    add_quat(0, 23170, 0, 23170);
    add_quat(0, -23170, 0, 23170);
    add_quat(23170, 0, 23170, 0);
    add_quat(16384, 16384, 16384, 16384);
    add_quat(0, 0, 32767, 1);
    add_quat(1, 0, 0, 0);
    add_quat(0, 0, 0, -1);
    add_quat(-32768, 0, 0, 0, 1'b1);
    add_quat(0, 0, -32768, 0);
    add_quat(32767, -32768, 32767, -32768);
    add_quat(100, -200, 300, 32000);
    for (int i = 0; i < 550; i++) begin
      if ($urandom_range(0, 9) < 3) begin
        add_quat($urandom, $urandom, $urandom, $urandom, (i % 137) == 50);
      end else begin
        a = $itor($urandom_range(0, 65535)) - 32768.0;
        b = $itor($urandom_range(0, 65535)) - 32768.0;
        c = $itor($urandom_range(0, 65535)) - 32768.0;
        d = $itor($urandom_range(0, 65535)) - 32768.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) n = 1.0;
        add_quat($rtoi(a / n * 32767.0), $rtoi(b / n * 32767.0),
                 $rtoi(c / n * 32767.0), $rtoi(d / n * 32767.0), (i % 137) == 50);
      end
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (quat_jobs.size() > 0 || start) @(posedge clk_i);
    while (euler_expected.size() > 0) @(posedge clk_i);
    repeat (LAT_CYC + 10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule

// ----- quaternion_to_yaw_pitch_roll_core.f -----
+incdir+design
design/qtypr_pkg.sv
design/qtypr_atan2.sv
design/quaternion_to_yaw_pitch_roll_core.sv
sim/tb_quaternion_to_yaw_pitch_roll_core.sv
